@@ design/sdar_pkg.sv @@
package sdar_pkg;

  localparam int ATAN_LEN = 30;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // 1/K in Q30
  localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;

  // internal angle: 2^32 per turn, with headroom
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sh8000_0000);

  function automatic logic signed [ZW-1:0] atan_at(input int i);
    return $signed({2'b00, ATAN_TAB[i]});
  endfunction

endpackage

@@ design/sdar_sincos.sv @@
module sdar_sincos #(
  parameter int ANGLE_BITS       = 16,
  parameter int VECTOR_FRAC_BITS = 16,
  parameter int CORDIC_STEPS     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [ANGLE_BITS-1:0]              ang_i [5],
  output logic                               out_valid,
  output logic signed [VECTOR_FRAC_BITS+2:0] cos_o [5],
  output logic signed [VECTOR_FRAC_BITS+2:0] sin_o [5]
);
  import sdar_pkg::*;

  localparam int VW = VECTOR_FRAC_BITS + 3;
  localparam int N  = CORDIC_STEPS;
  localparam longint INV_L = longint'(INV_GAIN_Q30);
  localparam longint X0_L = (VECTOR_FRAC_BITS == 30) ? INV_L :
    ((INV_L + (64'sd1 <<< (29 - VECTOR_FRAC_BITS))) >>> (30 - VECTOR_FRAC_BITS));
  localparam logic signed [VW-1:0] X0 = VW'(X0_L);

  logic signed [VW-1:0] x_r    [0:N][5];
  logic signed [VW-1:0] y_r    [0:N][5];
  logic signed [ZW-1:0] z_r    [0:N][5];
  logic                 flip_r [0:N][5];
  logic                 vld_r  [0:N+1];

  logic [31:0]          t_w    [5];
  logic                 flip_w [5];
  logic [31:0]          tf_w   [5];

  // fold second and third quadrant onto the first and fourth
  always_comb begin
    for (int l = 0; l < 5; l++) begin
      t_w[l]    = {ang_i[l], (32 - ANGLE_BITS)'(0)};
      flip_w[l] = (t_w[l][31:30] == 2'd1) || (t_w[l][31:30] == 2'd2);
      tf_w[l]   = flip_w[l] ? (t_w[l] - 32'h8000_0000) : t_w[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 5; l++) begin
        x_r[0][l]    <= X0;
        y_r[0][l]    <= '0;
        z_r[0][l]    <= {{(ZW-32){tf_w[l][31]}}, tf_w[l]};
        flip_r[0][l] <= flip_w[l];
      end
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 5; l++) begin
          if (z_r[k-1][l] >= 0) begin
            x_r[k][l] <= x_r[k-1][l] - (y_r[k-1][l] >>> (k-1));
            y_r[k][l] <= y_r[k-1][l] + (x_r[k-1][l] >>> (k-1));
            z_r[k][l] <= z_r[k-1][l] - atan_at(k-1);
          end else begin
            x_r[k][l] <= x_r[k-1][l] + (y_r[k-1][l] >>> (k-1));
            y_r[k][l] <= y_r[k-1][l] - (x_r[k-1][l] >>> (k-1));
            z_r[k][l] <= z_r[k-1][l] + atan_at(k-1);
          end
          flip_r[k][l] <= flip_r[k-1][l];
        end
      end
    end
  end

  logic signed [VW-1:0] cos_r [5];
  logic signed [VW-1:0] sin_r [5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 5; l++) begin
        cos_r[l] <= flip_r[N][l] ? -x_r[N][l] : x_r[N][l];
        sin_r[l] <= flip_r[N][l] ? -y_r[N][l] : y_r[N][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N + 1; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= N + 1; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign cos_o     = cos_r;
  assign sin_o     = sin_r;
  assign out_valid = vld_r[N+1];

endmodule

@@ design/sdar_rodrigues.sv @@
module sdar_rodrigues #(
  parameter int VECTOR_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [VECTOR_FRAC_BITS+2:0] cos_i [5],
  input  logic signed [VECTOR_FRAC_BITS+2:0] sin_i [5],
  output logic                               out_valid,
  output logic signed [VECTOR_FRAC_BITS+2:0] bx_o,
  output logic signed [VECTOR_FRAC_BITS+2:0] by_o,
  output logic signed [VECTOR_FRAC_BITS+2:0] bz_o
);
  import sdar_pkg::*;

  localparam int F  = VECTOR_FRAC_BITS;
  localparam int VW = F + 3;
  localparam int PW = 2 * VW;
  localparam int NST = 6;

  typedef logic signed [VW-1:0] vec_t;

  function automatic vec_t fmul(input vec_t a, input vec_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + (PW'(1) <<< (F - 1));
    return VW'(p >>> F);
  endfunction

  logic vld_r [NST];

  // stage 1: unit vectors
  vec_t vx1_r, vy1_r, vz1_r, kx1_r, ky1_r, kz1_r, cb1_r, sb1_r;
  // stage 2: pairwise products
  vec_t p_kyvz_r, p_kzvy_r, p_kzvx_r, p_kxvz_r, p_kxvy_r, p_kyvx_r;
  vec_t p_kxvx_r, p_kyvy_r, p_kzvz_r;
  vec_t vx2_r, vy2_r, vz2_r, kx2_r, ky2_r, kz2_r, cb2_r, sb2_r, omc2_r;
  // stage 3: cross and dot
  vec_t cx3_r, cy3_r, cz3_r, kv3_r;
  vec_t vx3_r, vy3_r, vz3_r, kx3_r, ky3_r, kz3_r, cb3_r, sb3_r, omc3_r;
  // stage 4
  vec_t w4_r, vxc4_r, vyc4_r, vzc4_r, cxs4_r, cys4_r, czs4_r, kx4_r, ky4_r, kz4_r;
  // stage 5
  vec_t sx5_r, sy5_r, sz5_r, kwx5_r, kwy5_r, kwz5_r;
  // stage 6
  vec_t bx6_r, by6_r, bz6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx1_r <= fmul(sin_i[1], cos_i[0]);
      vy1_r <= fmul(sin_i[1], sin_i[0]);
      vz1_r <= cos_i[1];
      kx1_r <= fmul(sin_i[3], cos_i[2]);
      ky1_r <= fmul(sin_i[3], sin_i[2]);
      kz1_r <= cos_i[3];
      cb1_r <= cos_i[4];
      sb1_r <= sin_i[4];

      p_kyvz_r <= fmul(ky1_r, vz1_r);
      p_kzvy_r <= fmul(kz1_r, vy1_r);
      p_kzvx_r <= fmul(kz1_r, vx1_r);
      p_kxvz_r <= fmul(kx1_r, vz1_r);
      p_kxvy_r <= fmul(kx1_r, vy1_r);
      p_kyvx_r <= fmul(ky1_r, vx1_r);
      p_kxvx_r <= fmul(kx1_r, vx1_r);
      p_kyvy_r <= fmul(ky1_r, vy1_r);
      p_kzvz_r <= fmul(kz1_r, vz1_r);
      vx2_r  <= vx1_r;
      vy2_r  <= vy1_r;
      vz2_r  <= vz1_r;
      kx2_r  <= kx1_r;
      ky2_r  <= ky1_r;
      kz2_r  <= kz1_r;
      cb2_r  <= cb1_r;
      sb2_r  <= sb1_r;
      omc2_r <= (VW'(1) <<< F) - cb1_r;

      cx3_r  <= p_kyvz_r - p_kzvy_r;
      cy3_r  <= p_kzvx_r - p_kxvz_r;
      cz3_r  <= p_kxvy_r - p_kyvx_r;
      kv3_r  <= p_kxvx_r + p_kyvy_r + p_kzvz_r;
      vx3_r  <= vx2_r;
      vy3_r  <= vy2_r;
      vz3_r  <= vz2_r;
      kx3_r  <= kx2_r;
      ky3_r  <= ky2_r;
      kz3_r  <= kz2_r;
      cb3_r  <= cb2_r;
      sb3_r  <= sb2_r;
      omc3_r <= omc2_r;

      w4_r   <= fmul(kv3_r, omc3_r);
      vxc4_r <= fmul(vx3_r, cb3_r);
      vyc4_r <= fmul(vy3_r, cb3_r);
      vzc4_r <= fmul(vz3_r, cb3_r);
      cxs4_r <= fmul(cx3_r, sb3_r);
      cys4_r <= fmul(cy3_r, sb3_r);
      czs4_r <= fmul(cz3_r, sb3_r);
      kx4_r  <= kx3_r;
      ky4_r  <= ky3_r;
      kz4_r  <= kz3_r;

      sx5_r  <= vxc4_r + cxs4_r;
      sy5_r  <= vyc4_r + cys4_r;
      sz5_r  <= vzc4_r + czs4_r;
      kwx5_r <= fmul(kx4_r, w4_r);
      kwy5_r <= fmul(ky4_r, w4_r);
      kwz5_r <= fmul(kz4_r, w4_r);

      bx6_r <= sx5_r + kwx5_r;
      by6_r <= sy5_r + kwy5_r;
      bz6_r <= sz5_r + kwz5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign bx_o      = bx6_r;
  assign by_o      = by6_r;
  assign bz_o      = bz6_r;
  assign out_valid = vld_r[NST-1];

endmodule

@@ design/sdar_atan2.sv @@
module sdar_atan2 #(
  parameter int VECTOR_FRAC_BITS = 16,
  parameter int CORDIC_STEPS     = 16,
  parameter int AUX_W            = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [VECTOR_FRAC_BITS+2:0] x_i,
  input  logic signed [VECTOR_FRAC_BITS+2:0] y_i,
  input  logic [AUX_W-1:0]                   aux_i,
  output logic                               out_valid,
  output logic signed [sdar_pkg::ZW-1:0]     ang_o,
  output logic signed [VECTOR_FRAC_BITS+2:0] mag_o,
  output logic [AUX_W-1:0]                   aux_o
);
  import sdar_pkg::*;

  localparam int VW = VECTOR_FRAC_BITS + 3;
  localparam int N  = CORDIC_STEPS;
  localparam int MW = VW + 32;

  logic signed [VW-1:0] x_r    [0:N];
  logic signed [VW-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r    [0:N];
  logic                 neg_r  [0:N];
  logic                 zero_r [0:N];
  logic [AUX_W-1:0]     aux_r  [0:N];
  logic                 vld_r  [0:N+1];

  // left half plane: mirror through the origin, add half a turn later
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= (x_i < 0) ? -x_i : x_i;
      y_r[0]    <= (x_i < 0) ? -y_i : y_i;
      z_r[0]    <= '0;
      neg_r[0]  <= (x_i < 0);
      zero_r[0] <= (x_i == 0) && (y_i == 0);
      aux_r[0]  <= aux_i;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + atan_at(k-1);
        end else begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - atan_at(k-1);
        end
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
        aux_r[k]  <= aux_r[k-1];
      end
    end
  end

  logic signed [MW-1:0] prod_w;
  logic signed [ZW-1:0] ang_r;
  logic signed [VW-1:0] mag_r;
  logic [AUX_W-1:0]     auxo_r;

  assign prod_w = (MW'(x_r[N]) * MW'($signed({1'b0, INV_GAIN_Q30})))
                + (MW'(1) <<< 29);

  always_ff @(posedge clk) begin
    if (en) begin
      auxo_r <= aux_r[N];
      if (zero_r[N]) begin
        ang_r <= '0;
        mag_r <= '0;
      end else begin
        ang_r <= z_r[N] + (neg_r[N] ? HALF_TURN : ZW'(0));
        mag_r <= VW'(prod_w >>> 30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N + 1; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= N + 1; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign ang_o     = ang_r;
  assign mag_o     = mag_r;
  assign aux_o     = auxo_r;
  assign out_valid = vld_r[N+1];

endmodule

@@ design/sky_direction_axis_rotation.sv @@
// Path from input beat to output beat:
//   sine/cosine CORDIC, six multiply/add stages, two chained atan2 CORDICs, output register.
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module sky_direction_axis_rotation #(
  parameter int ANGLE_BITS       = 16,
  parameter int VECTOR_FRAC_BITS = 16,
  parameter int CORDIC_STEPS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // point_azimuth, point_zenith, axis_azimuth, axis_zenith, rotation_angle
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // rotated_azimuth (signed), rotated_zenith
  output logic [31:0] out_tdata
);
  import sdar_pkg::*;

  localparam int VW = VECTOR_FRAC_BITS + 3;
  localparam int A  = ANGLE_BITS;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic [A-1:0] ang_w [5];
  always_comb begin
    for (int l = 0; l < 5; l++) ang_w[l] = A'(in_tdata[16*l +: 16]);
  end

  logic                 sc_valid;
  logic signed [VW-1:0] cos_w [5];
  logic signed [VW-1:0] sin_w [5];

  sdar_sincos #(
    .ANGLE_BITS(ANGLE_BITS), .VECTOR_FRAC_BITS(VECTOR_FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_sincos (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid && in_tready),
    .ang_i(ang_w), .out_valid(sc_valid), .cos_o(cos_w), .sin_o(sin_w)
  );

  logic                 rd_valid;
  logic signed [VW-1:0] bx_w, by_w, bz_w;

  sdar_rodrigues #(.VECTOR_FRAC_BITS(VECTOR_FRAC_BITS)) u_rodrigues (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sc_valid),
    .cos_i(cos_w), .sin_i(sin_w), .out_valid(rd_valid),
    .bx_o(bx_w), .by_o(by_w), .bz_o(bz_w)
  );

  logic                 az_valid;
  logic signed [ZW-1:0] azi_w;
  logic signed [VW-1:0] r_w;
  logic [VW-1:0]        bz_d_w;

  sdar_atan2 #(
    .VECTOR_FRAC_BITS(VECTOR_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .AUX_W(VW)
  ) u_atan_azi (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(rd_valid),
    .x_i(bx_w), .y_i(by_w), .aux_i(bz_w),
    .out_valid(az_valid), .ang_o(azi_w), .mag_o(r_w), .aux_o(bz_d_w)
  );

  logic                 ze_valid;
  logic signed [ZW-1:0] zen_w;
  logic [ZW-1:0]        azi_d_w;

  sdar_atan2 #(
    .VECTOR_FRAC_BITS(VECTOR_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .AUX_W(ZW)
  ) u_atan_zen (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(az_valid),
    .x_i($signed(bz_d_w)), .y_i(r_w), .aux_i(azi_w),
    .out_valid(ze_valid), .ang_o(zen_w), .mag_o(), .aux_o(azi_d_w)
  );

  // round both angles to ANGLE_BITS, ties upward
  logic [31:0]          a32_w;
  logic [A-1:0]         azq_w;
  logic signed [ZW-1:0] zcl_w;
  logic [32:0]          zsum_w;
  logic [A-1:0]         zeq_w;

  always_comb begin
    a32_w = azi_d_w[31:0] + (32'd1 << (31 - A));
    azq_w = a32_w[31 -: A];
    if (zen_w < 0)              zcl_w = '0;
    else if (zen_w > HALF_TURN) zcl_w = HALF_TURN;
    else                        zcl_w = zen_w;
    zsum_w = zcl_w[32:0] + (33'd1 << (31 - A));
    zeq_w  = A'(zsum_w >> (32 - A));
  end

  logic        out_valid_r;
  logic [15:0] azi_out_r, zen_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ze_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      azi_out_r <= 16'($signed(azq_w));
      zen_out_r <= 16'(zeq_w);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {zen_out_r, azi_out_r};

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");

  a_zenith_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ANGLE_BITS <= 16) |->
      out_tdata[31:16] <= 16'(32'd1 << (ANGLE_BITS - 1)))
    else $error("zenith beyond half turn");

endmodule
